>>> hw/rtl/acsp_pkg.sv
// Shared types and constants for the ASCII command sentence parser.
`default_nettype none

package acsp_pkg;

  localparam int unsigned MAX_FIELDS = 12;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned TAG_LEN    = 5;
  localparam int unsigned VAL_W      = 32;

  // Boolean field positions.
  localparam logic [FIDX_W-1:0] ELEVA_FORCE_IDX = 4'd2;
  localparam logic [FIDX_W-1:0] CLICK_STATE_IDX = 4'd0;

  // Tags, first character in the top byte.
  localparam logic [39:0] TAG_WHEEL = "WHEEL";
  localparam logic [39:0] TAG_LASER = "LASER";
  localparam logic [39:0] TAG_ELEVA = "ELEVA";
  localparam logic [39:0] TAG_CLICK = "CLICK";
  localparam logic [39:0] TAG_FPVSV = "FPVSV";
  localparam logic [39:0] TAG_HEART = "HEART";

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [VAL_W-1:0] SAT_MAG = 32'h8000_0000;
  localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    KIND_UNKNOWN  = 3'd0,
    KIND_WHEEL    = 3'd1,
    KIND_LASER    = 3'd2,
    KIND_ELEVA    = 3'd3,
    KIND_CLICK    = 3'd4,
    KIND_FPVSV    = 3'd5,
    KIND_HEART    = 3'd6,
    KIND_OVERFLOW = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_WS    = 3'd1,
    PH_INT   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_SKIP  = 3'd4,
    PH_END   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_RX   = 2'd0,
    ST_READ = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  // Control from the sentence sequencer to the token parser.
  typedef struct packed {
    logic step;     // a byte at a token position
    logic eos;      // sentence terminator
    logic clear;    // drop the token in progress
    logic fixed;    // current command uses milli-unit fields
    logic as_bool;  // current field is a boolean
  } tok_ctl_t;

  typedef struct packed {
    logic             fin;
    logic [VAL_W-1:0] value;
  } tok_res_t;

  function automatic kind_e tag_kind(input logic [39:0] tag);
    kind_e k;
    k = KIND_UNKNOWN;
    if (tag == TAG_WHEEL) k = KIND_WHEEL;
    else if (tag == TAG_LASER) k = KIND_LASER;
    else if (tag == TAG_ELEVA) k = KIND_ELEVA;
    else if (tag == TAG_CLICK) k = KIND_CLICK;
    else if (tag == TAG_FPVSV) k = KIND_FPVSV;
    else if (tag == TAG_HEART) k = KIND_HEART;
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/acsp_field_ram.sv
// Field value memory: one write port, one registered read port.
`default_nettype none

module acsp_field_ram (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [acsp_pkg::FIDX_W-1:0]       waddr_i,
  input  wire logic [acsp_pkg::VAL_W-1:0]        wdata_i,
  input  wire logic                              re_i,
  input  wire logic [acsp_pkg::FIDX_W-1:0]       raddr_i,
  output logic      [acsp_pkg::VAL_W-1:0]        rdata_o
);

  logic [acsp_pkg::VAL_W-1:0] mem_q [acsp_pkg::MAX_FIELDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/acsp_token.sv
// Token parser: digit accumulation, sign, fraction and final value scaling.
`default_nettype none

module acsp_token (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire acsp_pkg::tok_ctl_t ctl_i,
  input  wire logic [7:0]         byte_i,
  output acsp_pkg::tok_res_t      res_o
);

  acsp_pkg::phase_e phase_q, phase_d;
  logic [acsp_pkg::VAL_W-1:0] acc_q, acc_d;
  logic neg_q, neg_d;
  logic [1:0] frac_q, frac_d;

  logic is_digit, is_dot, is_space;
  logic [35:0] ten;
  logic [acsp_pkg::VAL_W-1:0] acc_ten;
  logic [9:0] scale;
  logic [41:0] prod;
  logic [acsp_pkg::VAL_W-1:0] mag;
  logic tok_fin;
  logic [acsp_pkg::VAL_W-1:0] tok_value;

  assign res_o = {tok_fin, tok_value};

  always_comb begin
    is_digit = (byte_i >= acsp_pkg::CH_ZERO) && (byte_i <= acsp_pkg::CH_NINE);
    is_dot   = (byte_i == acsp_pkg::CH_DOT) && ctl_i.fixed;
    is_space = (byte_i == acsp_pkg::CH_SPACE) ||
               ((byte_i >= acsp_pkg::CH_TAB) && (byte_i <= acsp_pkg::CH_CR));

    // acc * 10 + digit as shift and add, capped at 2^31.
    ten = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, byte_i[3:0]};
    acc_ten = (ten > {4'b0, acsp_pkg::SAT_MAG}) ? acsp_pkg::SAT_MAG : ten[31:0];

    // Missing fraction digits of a milli-unit field scale the magnitude up.
    if (ctl_i.fixed) begin
      case (frac_q)
        2'd0:    scale = 10'd1000;
        2'd1:    scale = 10'd100;
        2'd2:    scale = 10'd10;
        default: scale = 10'd1;
      endcase
    end else begin
      scale = 10'd1;
    end
    prod = {10'b0, acc_q} * {32'b0, scale};
    mag  = (prod > {10'b0, acsp_pkg::SAT_MAG}) ? acsp_pkg::SAT_MAG : prod[31:0];

    if (ctl_i.as_bool) begin
      tok_value = {31'b0, (mag != '0)};
    end else if (neg_q) begin
      tok_value = '0 - mag;
    end else begin
      tok_value = mag[31] ? acsp_pkg::POS_MAX : mag;
    end
  end

  always_comb begin
    acsp_pkg::phase_e ph;
    ph        = phase_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    frac_d    = frac_q;
    tok_fin   = 1'b0;

    if (ctl_i.clear) begin
      tok_fin = ctl_i.eos && (phase_q != acsp_pkg::PH_START) &&
                (phase_q != acsp_pkg::PH_END);
      phase_d = acsp_pkg::PH_START;
      acc_d   = '0;
      neg_d   = 1'b0;
      frac_d  = '0;
    end else if (ctl_i.step && (phase_q != acsp_pkg::PH_END)) begin
      if ((byte_i == acsp_pkg::CH_NUL) || (byte_i == acsp_pkg::CH_COMMA)) begin
        tok_fin = (phase_q != acsp_pkg::PH_START);
        acc_d   = '0;
        neg_d   = 1'b0;
        frac_d  = '0;
        // A NUL ends token parsing for the rest of the sentence.
        phase_d = (byte_i == acsp_pkg::CH_NUL) ? acsp_pkg::PH_END : acsp_pkg::PH_START;
      end else begin
        ph = (phase_q == acsp_pkg::PH_START) ? acsp_pkg::PH_WS : phase_q;
        phase_d = ph;
        case (ph)
          acsp_pkg::PH_WS: begin
            if (is_space) begin
              phase_d = acsp_pkg::PH_WS;
            end else if ((byte_i == acsp_pkg::CH_PLUS) || (byte_i == acsp_pkg::CH_MINUS)) begin
              neg_d   = (byte_i == acsp_pkg::CH_MINUS);
              phase_d = acsp_pkg::PH_INT;
            end else if (is_digit) begin
              acc_d   = acc_ten;
              phase_d = acsp_pkg::PH_INT;
            end else if (is_dot) begin
              phase_d = acsp_pkg::PH_FRAC;
            end else begin
              phase_d = acsp_pkg::PH_SKIP;
            end
          end
          acsp_pkg::PH_INT: begin
            if (is_digit) begin
              acc_d = acc_ten;
            end else if (is_dot) begin
              phase_d = acsp_pkg::PH_FRAC;
            end else begin
              phase_d = acsp_pkg::PH_SKIP;
            end
          end
          acsp_pkg::PH_FRAC: begin
            if (is_digit) begin
              // Digits past the third are dropped.
              if (frac_q != 2'd3) begin
                acc_d  = acc_ten;
                frac_d = frac_q + 2'd1;
              end
            end else begin
              phase_d = acsp_pkg::PH_SKIP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= acsp_pkg::PH_START;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      frac_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      frac_q  <= frac_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ascii_command_sentence_parser.sv
// Top level of the ASCII command sentence parser: framing, tag match and result sequencing.
//
//   Channel | Handshake              | Payload
//   in      | in_valid_i/in_ready_o   | rx_byte_i, stop_active_i
//   out     | out_valid_o/out_ready_i | kind_o, field_index_o, value_o, last_o
//
// A byte is taken every cycle while no sentence results are pending.
// A terminator starts a burst: each field result passes through a field memory
// read and then the output register, and is held there while the consumer stalls.
// Unknown, blocked and overflow sentences give a single result with no memory read.
// Reset clears all control state; the field memory needs no clearing.
`default_nettype none

module ascii_command_sentence_parser #(
  parameter int unsigned MAX_SENTENCE = 64,
  parameter int unsigned WHEEL_PAIRS  = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        stop_active_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [3:0]       field_index_o,
  output logic signed [31:0] value_o,
  output logic             last_o
);

  localparam int unsigned POS_W = $clog2(MAX_SENTENCE);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SENTENCE - 1);
  localparam logic [POS_W-1:0] POS_TAG   = POS_W'(acsp_pkg::TAG_LEN);
  localparam int unsigned FW = acsp_pkg::FIDX_W;
  localparam int unsigned VW = acsp_pkg::VAL_W;

  acsp_pkg::state_e state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [39:0]      tag_q, tag_d;
  logic             discard_q, discard_d;
  logic [FW-1:0]    fc_q, fc_d;
  acsp_pkg::kind_e  ekind_q, ekind_d;
  logic [FW-1:0]    en_q, en_d;
  logic [FW-1:0]    ecnt_q, ecnt_d;
  logic [FW-1:0]    k_q, k_d;
  logic             fwd_q, fwd_d;
  logic [VW-1:0]    fwd_data_q;
  acsp_pkg::kind_e  okind_q, okind_d;
  logic [FW-1:0]    oidx_q, oidx_d;
  logic [VW-1:0]    oval_q, oval_d;
  logic             olast_q, olast_d;

  acsp_pkg::kind_e    kind;
  logic [FW-1:0]      n_fields;
  logic               accept;
  logic               we;
  logic               re;
  logic [FW-1:0]      raddr;
  logic [VW-1:0]      rdata;
  logic [VW-1:0]      rd_value;
  logic [2:0]         tag_idx;
  acsp_pkg::tok_ctl_t tok_ctl;
  acsp_pkg::tok_res_t tok_res;

  acsp_token u_token (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (tok_ctl),
    .byte_i (rx_byte_i),
    .res_o  (tok_res)
  );

  acsp_field_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fc_q),
    .wdata_i (tok_res.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    kind = acsp_pkg::tag_kind(tag_q);
    case (kind)
      acsp_pkg::KIND_WHEEL: n_fields = FW'(2 * WHEEL_PAIRS);
      acsp_pkg::KIND_LASER: n_fields = 4'd1;
      acsp_pkg::KIND_ELEVA: n_fields = 4'd3;
      acsp_pkg::KIND_CLICK: n_fields = 4'd1;
      acsp_pkg::KIND_FPVSV: n_fields = 4'd2;
      acsp_pkg::KIND_HEART: n_fields = 4'd1;
      default:              n_fields = 4'd0;
    endcase
  end

  assign accept   = in_valid_i && (state_q == acsp_pkg::ST_RX);
  assign we       = tok_res.fin && (fc_q < n_fields);
  assign tag_idx  = 3'd4 - pos_q[2:0];
  // The write at the terminator may land on the entry read in the same cycle.
  assign rd_value = fwd_q ? fwd_data_q : rdata;
  assign fwd_d    = we && re && (fc_q == raddr);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    tag_d     = tag_q;
    discard_d = discard_q;
    fc_d      = fc_q;
    ekind_d   = ekind_q;
    en_d      = en_q;
    ecnt_d    = ecnt_q;
    k_d       = k_q;
    okind_d   = okind_q;
    oidx_d    = oidx_q;
    oval_d    = oval_q;
    olast_d   = olast_q;
    re        = 1'b0;
    raddr     = k_q;

    tok_ctl.step    = 1'b0;
    tok_ctl.eos     = 1'b0;
    tok_ctl.clear   = 1'b0;
    tok_ctl.fixed   = (kind == acsp_pkg::KIND_FPVSV) || (kind == acsp_pkg::KIND_HEART);
    tok_ctl.as_bool = ((kind == acsp_pkg::KIND_ELEVA) && (fc_q == acsp_pkg::ELEVA_FORCE_IDX)) ||
                      ((kind == acsp_pkg::KIND_CLICK) && (fc_q == acsp_pkg::CLICK_STATE_IDX));

    case (state_q)
      acsp_pkg::ST_RX: begin
        if (accept) begin
          if (rx_byte_i == acsp_pkg::CH_DOLLAR) begin
            tok_ctl.clear = 1'b1;
            pos_d         = '0;
            tag_d         = '0;
            fc_d          = '0;
            discard_d     = 1'b0;
          end else if (!discard_q) begin
            if (rx_byte_i == acsp_pkg::CH_STAR) begin
              tok_ctl.clear = 1'b1;
              tok_ctl.eos   = 1'b1;
              pos_d         = '0;
              tag_d         = '0;
              fc_d          = '0;
              if ((n_fields == '0) ||
                  (stop_active_i && (kind != acsp_pkg::KIND_HEART))) begin
                okind_d = acsp_pkg::KIND_UNKNOWN;
                oidx_d  = '0;
                oval_d  = '0;
                olast_d = 1'b1;
                state_d = acsp_pkg::ST_OUT;
              end else begin
                ekind_d = kind;
                en_d    = n_fields;
                ecnt_d  = fc_q + FW'(we);
                k_d     = '0;
                re      = 1'b1;
                raddr   = '0;
                state_d = acsp_pkg::ST_READ;
              end
            end else if (pos_q < POS_LIMIT) begin
              if (pos_q < POS_TAG) begin
                tag_d[{tag_idx, 3'b000} +: 8] = rx_byte_i;
              end else if (pos_q > POS_TAG) begin
                tok_ctl.step = 1'b1;
                fc_d         = fc_q + FW'(we);
              end
              pos_d = pos_q + POS_W'(1);
            end else begin
              tok_ctl.clear = 1'b1;
              pos_d         = '0;
              tag_d         = '0;
              fc_d          = '0;
              discard_d     = 1'b1;
              okind_d       = acsp_pkg::KIND_OVERFLOW;
              oidx_d        = '0;
              oval_d        = '0;
              olast_d       = 1'b1;
              state_d       = acsp_pkg::ST_OUT;
            end
          end
        end
      end
      acsp_pkg::ST_READ: begin
        okind_d = ekind_q;
        oidx_d  = k_q;
        oval_d  = (k_q < ecnt_q) ? rd_value : '0;
        olast_d = ((k_q + FW'(1)) == en_q);
        state_d = acsp_pkg::ST_OUT;
      end
      acsp_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (olast_q) begin
            state_d = acsp_pkg::ST_RX;
          end else begin
            k_d     = k_q + FW'(1);
            re      = 1'b1;
            raddr   = k_q + FW'(1);
            state_d = acsp_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = acsp_pkg::ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= acsp_pkg::ST_RX;
      pos_q     <= '0;
      tag_q     <= '0;
      discard_q <= 1'b0;
      fc_q      <= '0;
      ekind_q   <= acsp_pkg::KIND_UNKNOWN;
      en_q      <= '0;
      ecnt_q    <= '0;
      k_q       <= '0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      tag_q     <= tag_d;
      discard_q <= discard_d;
      fc_q      <= fc_d;
      ekind_q   <= ekind_d;
      en_q      <= en_d;
      ecnt_q    <= ecnt_d;
      k_q       <= k_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= tok_res.value;
    okind_q    <= okind_d;
    oidx_q     <= oidx_d;
    oval_q     <= oval_d;
    olast_q    <= olast_d;
  end

  assign in_ready_o    = (state_q == acsp_pkg::ST_RX);
  assign out_valid_o   = (state_q == acsp_pkg::ST_OUT);
  assign kind_o        = okind_q;
  assign field_index_o = oidx_q;
  assign value_o       = oval_q;
  assign last_o        = olast_q;

endmodule

`default_nettype wire

>>> test/sentence_checker.sv
// Result checker for the ASCII command sentence parser: predicts every result and compares it.
`timescale 1ns / 100ps

module sentence_checker
  import acsp_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 64,
  parameter int unsigned WHEEL_PAIRS  = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        stop_active_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [3:0]  field_index_i,
  input  wire logic [31:0] value_i,
  input  wire logic        last_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  idx;
    logic [31:0] value;
    logic        last;
  } field_res_t;

  // Shadow copy of the parser state.
  logic [6:0]  sent_pos;
  logic [7:0]  tag_byte [TAG_LEN];
  logic        dropping;
  phase_e      phase;
  logic [31:0] mag;
  logic        minus;
  logic [1:0]  frac_cnt;
  logic [3:0]  stored;
  logic [31:0] field_val [MAX_FIELDS];

  field_res_t  expected_q [$];
  int          fail_count = 0;

  function automatic kind_e match_tag();
    logic [39:0] word;
    word = {tag_byte[0], tag_byte[1], tag_byte[2], tag_byte[3], tag_byte[4]};
    case (word)
      TAG_WHEEL: return KIND_WHEEL;
      TAG_LASER: return KIND_LASER;
      TAG_ELEVA: return KIND_ELEVA;
      TAG_CLICK: return KIND_CLICK;
      TAG_FPVSV: return KIND_FPVSV;
      TAG_HEART: return KIND_HEART;
      default:   return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic int field_total(input kind_e k);
    case (k)
      KIND_WHEEL: return 2 * WHEEL_PAIRS;
      KIND_LASER: return 1;
      KIND_ELEVA: return 3;
      KIND_CLICK: return 1;
      KIND_FPVSV: return 2;
      KIND_HEART: return 1;
      default:    return 0;
    endcase
  endfunction

  // Decimal shift with the magnitude capped at 2^31.
  function automatic logic [31:0] shift_digit(input logic [31:0] m, input logic [7:0] d);
    logic [35:0] t;
    t = {4'b0, m} * 36'd10 + {28'b0, d};
    if (t > {4'b0, SAT_MAG}) t = {4'b0, SAT_MAG};
    return t[31:0];
  endfunction

  task automatic clear_token();
    mag      = '0;
    minus    = 1'b0;
    frac_cnt = '0;
    phase    = PH_START;
  endtask

  task automatic clear_sentence();
    sent_pos = '0;
    stored   = '0;
    for (int i = 0; i < TAG_LEN; i++) tag_byte[i] = '0;
    clear_token();
  endtask

  task automatic push_result(input kind_e k, input int idx, input logic [31:0] v,
                             input logic fin);
    field_res_t r;
    r.kind  = k;
    r.idx   = idx[3:0];
    r.value = v;
    r.last  = fin;
    expected_q.push_back(r);
  endtask

  task automatic close_token(input kind_e k);
    logic [31:0] m;
    logic [31:0] v;
    logic        is_flag;
    if (stored < field_total(k) && stored < MAX_FIELDS) begin
      m = mag;
      if (k == KIND_FPVSV || k == KIND_HEART) begin
        for (int fd = frac_cnt; fd < 3; fd++) m = shift_digit(m, 8'd0);
      end
      is_flag = (k == KIND_ELEVA && stored == ELEVA_FORCE_IDX) ||
                (k == KIND_CLICK && stored == CLICK_STATE_IDX);
      if (is_flag) v = (m != 0) ? 32'd1 : 32'd0;
      else if (minus) v = 32'd0 - m;
      else v = (m > POS_MAX) ? POS_MAX : m;
      field_val[stored] = v;
      stored++;
    end
    clear_token();
  endtask

  task automatic token_byte(input logic [7:0] c, input kind_e k);
    logic num;
    logic dot;
    logic blank;
    num   = (c >= CH_ZERO) && (c <= CH_NINE);
    dot   = (c == CH_DOT) && (k == KIND_FPVSV || k == KIND_HEART);
    blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    if (phase == PH_END) return;
    if (c == CH_NUL || c == CH_COMMA) begin
      if (phase != PH_START) close_token(k);
      // A NUL ends token parsing for the rest of the sentence.
      if (c == CH_NUL) phase = PH_END;
      return;
    end
    if (phase == PH_START) phase = PH_WS;
    case (phase)
      PH_WS: begin
        if (!blank) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            minus = (c == CH_MINUS);
            phase = PH_INT;
          end else if (num) begin
            mag   = shift_digit(mag, c - CH_ZERO);
            phase = PH_INT;
          end else if (dot) begin
            phase = PH_FRAC;
          end else begin
            phase = PH_SKIP;
          end
        end
      end
      PH_INT: begin
        if (num) mag = shift_digit(mag, c - CH_ZERO);
        else if (dot) phase = PH_FRAC;
        else phase = PH_SKIP;
      end
      PH_FRAC: begin
        if (num) begin
          // Digits past the third are dropped, which truncates toward zero.
          if (frac_cnt < 3) begin
            mag = shift_digit(mag, c - CH_ZERO);
            frac_cnt++;
          end
        end else begin
          phase = PH_SKIP;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic stop);
    kind_e k;
    int    n;
    int    i;
    if (c == CH_DOLLAR) begin
      clear_sentence();
      dropping = 1'b0;
      return;
    end
    if (dropping) return;
    if (c == CH_STAR) begin
      k = match_tag();
      n = field_total(k);
      if (phase != PH_START && phase != PH_END) close_token(k);
      if (n == 0 || (stop && k != KIND_HEART)) begin
        push_result(KIND_UNKNOWN, 0, '0, 1'b1);
      end else begin
        for (i = 0; i < n && i < MAX_FIELDS; i++)
          push_result(k, i, (i < stored) ? field_val[i] : '0, i + 1 == n);
      end
      clear_sentence();
      return;
    end
    if (sent_pos < MAX_SENTENCE - 1) begin
      if (sent_pos < TAG_LEN) tag_byte[sent_pos] = c;
      else if (sent_pos >= 6) token_byte(c, match_tag());
      sent_pos++;
      return;
    end
    clear_sentence();
    dropping = 1'b1;
    push_result(KIND_OVERFLOW, 0, '0, 1'b1);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, what, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_res_t want;
    if (!rst_ni) begin
      clear_sentence();
      dropping = 1'b0;
      for (int i = 0; i < MAX_FIELDS; i++) field_val[i] = '0;
      expected_q.delete();
      pending_o <= 0;
      errors_o  <= fail_count;
    end else begin
      if (in_valid_i && in_ready_i) predict_byte(rx_byte_i, stop_active_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual kind %0d index %0d value %0d last %0d",
                   $time, kind_i, field_index_i, $signed(value_i), last_i);
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("field_index", 32'(want.idx), 32'(field_index_i));
          check_field("value", want.value, value_i);
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      pending_o <= expected_q.size();
      errors_o  <= fail_count;
    end
  end

endmodule

>>> test/tb_top.sv
// Top of the sentence parser testbench: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import acsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte     = 8'h00;
  logic        stop_active = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  field_index;
  logic signed [31:0] value;
  logic        last;

  int errors;
  int pending;
  int cycles       = 0;
  int sent_count   = 0;
  int burst_left   = 0;
  int ready_mode   = 0;
  int ready_hold   = 0;

  string cmd_tags [6] = '{"WHEEL", "LASER", "ELEVA", "CLICK", "FPVSV", "HEART"};
  int    cmd_fields [6] = '{12, 1, 3, 1, 2, 1};

  ascii_command_sentence_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .stop_active_i (stop_active),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .field_index_o (field_index),
    .value_o       (value),
    .last_o        (last)
  );

  sentence_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .stop_active_i (stop_active),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .field_index_i (field_index),
    .value_i       (value),
    .last_i        (last),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The consumer switches between always ready, random stalls and heavy stalls.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_hold <= $urandom_range(8, 64);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Offers one byte and returns at the edge where the transaction completes.
  task automatic put_byte(input logic [7:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    stop_active <= st;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  // The stop flag is random on every byte except a terminator, which gets star_stop.
  task automatic send_text(input string s, input logic star_stop);
    logic st;
    for (int i = 0; i < s.len(); i++) begin
      st = (s[i] == CH_STAR) ? star_stop : 1'($urandom_range(0, 1));
      put_byte(s[i], st);
    end
  endtask

  function automatic string repeat_char(input string ch, input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, ch};
    return s;
  endfunction

  function automatic string blank_char();
    int w;
    w = $urandom_range(0, 5);
    if (w == 5) return " ";
    return $sformatf("%c", 8'(9 + w));
  endfunction

  function automatic string number_token(input bit fixed_pt, input bit brief);
    string t;
    string extremes [6];
    int    sel;
    extremes = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                 "2147483.647", "99999999999"};
    t   = "";
    sel = brief ? 4 : $urandom_range(0, 11);
    case (sel)
      0: t = "";
      1: t = {blank_char(), blank_char()};
      2: t = extremes[$urandom_range(0, 5)];
      3: t = ($urandom_range(0, 1) == 0) ? "x7" : "+-3";
      default: begin
        if (!brief && $urandom_range(0, 3) == 0) t = blank_char();
        case ($urandom_range(0, 3))
          0: t = {t, "-"};
          1: t = {t, "+"};
          default: ;
        endcase
        repeat (brief ? $urandom_range(1, 2) : $urandom_range(1, 6))
          t = {t, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 2) == 0) begin
          t = {t, "."};
          repeat ($urandom_range(0, 5)) t = {t, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(0, 7) == 0) t = {t, "z1"};
      end
    endcase
    return t;
  endfunction

  // A mostly well-formed command with random tag, separator and token content.
  task automatic send_command();
    string s;
    string sep;
    int    t;
    int    ntok;
    t = $urandom_range(0, 5);
    s = {"$", cmd_tags[t]};
    if ($urandom_range(0, 9) == 0) s.putc($urandom_range(1, 5), "Q");
    // A sentence may also start right after a terminator without a '$'.
    if ($urandom_range(0, 11) == 0) s = s.substr(1, s.len() - 1);
    sep = ($urandom_range(0, 3) == 0) ? $sformatf("%c", 8'($urandom_range(33, 126))) : ",";
    if (sep == "$" || sep == "*") sep = ",";
    send_text({s, sep}, 1'b0);
    ntok = $urandom_range(0, cmd_fields[t] + 2);
    for (int i = 0; i < ntok; i++) begin
      send_text(number_token(t >= 4, t == 0), 1'b0);
      if (i < ntok - 1 || $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 24) == 0) put_byte(CH_NUL, 1'($urandom_range(0, 1)));
        else put_byte(CH_COMMA, 1'($urandom_range(0, 1)));
      end
    end
    put_byte(CH_STAR, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int kind_pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the field extremes and the special cases.
    send_text("$WHEEL,-5,,7*", 1'b0);
    send_text("$CLICKx5z,1,2*", 1'b0);
    send_text("$FPVSV,.5,2.*", 1'b0);
    send_text("$FPVSV,2147483.648,-3000000*", 1'b0);
    send_text({"$HEART, ", blank_char(), "3.25*"}, 1'b0);
    send_text("$LASER,   *", 1'b0);
    send_text("$LASER,1.9*", 1'b0);
    // The stop flag blocks every command except the heartbeat.
    send_text("$LASER,5*", 1'b1);
    send_text("$HEART,1*", 1'b1);
    send_text("$LASR,1*", 1'b0);
    send_text("$LAS*", 1'b0);
    send_text("*", 1'b0);
    send_text("$LASER,12", 1'b0);
    put_byte(CH_NUL, 1'b0);
    send_text(",55*", 1'b0);
    send_text("$LA", 1'b0);
    put_byte(CH_NUL, 1'b0);
    send_text("SER,5*", 1'b0);
    send_text("$LASER,", 1'b0);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h80, 1'b0);
    send_text("3*", 1'b0);
    send_text({"$WHEEL,", repeat_char("1", 58), "*5*"}, 1'b0);

    // Random part: mostly commands, with noise, oversized and cut-off sentences.
    while (sent_count < 320) begin
      kind_pick = $urandom_range(0, 19);
      if (kind_pick < 15) begin
        send_command();
      end else if (kind_pick < 17) begin
        repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1)));
      end else if (kind_pick == 17) begin
        send_text({"$", cmd_tags[$urandom_range(0, 5)], ",",
                   repeat_char("1", $urandom_range(50, 70)), "*"}, 1'b0);
      end else if (kind_pick == 18) begin
        send_text({"$", cmd_tags[$urandom_range(0, 5)].substr(0, $urandom_range(0, 3))},
                  1'b0);
      end else begin
        send_text(($urandom_range(0, 1) == 0) ? "$*" : "*", 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/acsp_pkg.sv
hw/rtl/acsp_field_ram.sv
hw/rtl/acsp_token.sv
hw/rtl/ascii_command_sentence_parser.sv
test/sentence_checker.sv
test/tb_top.sv
